/* rtl/srq_pkg.sv */
// ----------------------------------------------------------------------------
// srq_pkg
// Shared types and codes for the shifting queue with search.
// ----------------------------------------------------------------------------
package srq_pkg;

    // command codes carried on the request channel
    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_SRCH = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // per-cycle operation broadcast to every cell
    typedef struct packed {
        logic load;   // a request is accepted this cycle
        logic enq;    // append at the tail (queue not full)
        logic deq;    // shift one place toward the head (queue not empty)
        logic srch;   // compare against the identifier
    } t_cell_op;

endpackage

/* rtl/srq_in_if.sv */
// ----------------------------------------------------------------------------
// srq_in_if
// Request channel: command and identifier with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] ident;

    modport source (output valid, output cmd, output ident, input ready);
    modport sink   (input valid, input cmd, input ident, output ready);
endinterface

/* rtl/srq_out_if.sv */
// ----------------------------------------------------------------------------
// srq_out_if
// Result channel: status, search result, removed head and occupancy.
// ----------------------------------------------------------------------------
interface srq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               found;
    logic [2:0]         position;
    logic signed [31:0] head_value;
    logic [3:0]         occupancy;

    modport source (output valid, output status, output found, output position,
                    output head_value, output occupancy, input ready);
    modport sink   (input valid, input status, input found, input position,
                    input head_value, input occupancy, output ready);
endinterface

/* rtl/srq_cell.sv */
// ----------------------------------------------------------------------------
// srq_cell
// One queue slot: holds an identifier, takes its neighbour's value on a
// dequeue, loads the new identifier when it is the tail, and registers a
// match flag for a search.
// ----------------------------------------------------------------------------
module srq_cell #(
    parameter int DEPTH    = 8,
    parameter int ID_WIDTH = 32,
    parameter int IDX      = 0
) (
    input  logic                           i_clk,
    input  srq_pkg::t_cell_op              i_op,
    input  logic [$clog2(DEPTH+1)-1:0]     i_count,
    input  logic [ID_WIDTH-1:0]            i_id,
    input  logic [ID_WIDTH-1:0]            i_next,
    output logic [ID_WIDTH-1:0]            o_data,
    output logic                           o_match
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [ID_WIDTH-1:0] r_slot;
    logic                r_match;

    // shift, load at the tail, and compare when occupied
    always_ff @(posedge i_clk) begin
        if (i_op.load) begin
            if (i_op.deq) begin
                r_slot <= i_next;
            end else if (i_op.enq && (i_count == IDX_C)) begin
                r_slot <= i_id;
            end
            r_match <= i_op.srch && (i_count > IDX_C) && (r_slot == i_id);
        end
    end

    assign o_data  = r_slot;
    assign o_match = r_match;
endmodule

/* rtl/srq_first_match.sv */
// ----------------------------------------------------------------------------
// srq_first_match
// Priority encoder: position of the lowest set match flag, nearest the head.
// ----------------------------------------------------------------------------
module srq_first_match #(
    parameter int DEPTH = 8
) (
    input  logic [DEPTH-1:0]         i_match,
    output logic                     o_any,
    output logic [$clog2(DEPTH)-1:0] o_index
);
    localparam int IW = $clog2(DEPTH);

    logic [DEPTH-1:0] w_low;

    // isolate the lowest set flag
    assign w_low = i_match & (~i_match + DEPTH'(1));
    assign o_any = |i_match;

    // encode the isolated flag
    always_comb begin
        o_index = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_low[i]) begin
                o_index = o_index | IW'(i);
            end
        end
    end
endmodule

/* rtl/shift_queue_with_search.sv */
// ----------------------------------------------------------------------------
// shift_queue_with_search
// Bounded first-in first-out queue held in a chain of shifting cells, with
// enqueue, dequeue and search for the first matching entry.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle, unless it stalls, and returns
// exactly one result for each, in order. In the cycle that takes the request
// every cell shifts, loads or compares its own slot in parallel and registers
// a match flag; once the output register is free, a priority encoder over
// those flags picks the first match and the result is loaded into the output
// register. While that register holds a result that has not been taken, one
// further request is still accepted before the block stalls.
// Identifiers are stored as their low ID_WIDTH bits; position and occupancy are
// reported in their field widths and wrap for depths beyond what those fields
// hold.
// ----------------------------------------------------------------------------
module shift_queue_with_search #(
    parameter int DEPTH    = 8,
    parameter int ID_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srq_in_if.sink    i_req,
    srq_out_if.source o_rsp
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    logic [CW-1:0]          r_count, n_count;
    logic                   r_s1_valid;
    srq_pkg::t_cmd          r_s1_cmd;
    srq_pkg::t_status       r_s1_status;
    logic [ID_WIDTH-1:0]    r_s1_head;
    logic [CW-1:0]          r_s1_occ;
    logic                   r_out_valid;
    srq_pkg::t_status       r_out_status;
    logic                   r_out_found;
    logic [2:0]             r_out_position;
    logic [31:0]            r_out_head;
    logic [3:0]             r_out_occ;

    srq_pkg::t_cmd          w_cmd;
    srq_pkg::t_status       w_status;
    srq_pkg::t_cell_op      w_op;
    logic                   w_accept;
    logic                   w_s2_adv;
    logic                   w_full;
    logic                   w_empty;
    logic [ID_WIDTH+31:0]   w_id_wide;
    logic [ID_WIDTH-1:0]    w_id;
    logic [ID_WIDTH-1:0]    w_data [DEPTH];
    logic [ID_WIDTH-1:0]    w_tail;
    logic [DEPTH-1:0]       w_match;
    logic                   w_any;
    logic [IW-1:0]          w_index;
    logic [IW+2:0]          w_pos_wide;
    logic [ID_WIDTH+31:0]   w_head_wide;
    logic [CW+3:0]          w_occ_wide;

    // handshake: the output register frees the first stage
    assign w_s2_adv    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || w_s2_adv;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_cmd     = srq_pkg::t_cmd'(i_req.cmd);
    assign w_full    = (r_count == FULL_C);
    assign w_empty   = (r_count == '0);
    assign w_id_wide = {{ID_WIDTH{1'b0}}, i_req.ident};
    assign w_id      = w_id_wide[ID_WIDTH-1:0];
    assign w_tail    = '0;

    // decode the command against the current fill
    always_comb begin
        w_op      = '0;
        w_op.load = w_accept;
        w_status  = srq_pkg::ST_OK;
        n_count   = r_count;
        unique case (w_cmd)
            srq_pkg::CMD_ENQ: begin
                if (w_full) begin
                    w_status = srq_pkg::ST_FULL;
                end else begin
                    w_op.enq = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            srq_pkg::CMD_DEQ: begin
                if (w_empty) begin
                    w_status = srq_pkg::ST_EMPTY;
                end else begin
                    w_op.deq = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            srq_pkg::CMD_SRCH: begin
                if (w_empty) begin
                    w_status = srq_pkg::ST_EMPTY;
                end else begin
                    w_op.srch = 1'b1;
                end
            end
            srq_pkg::CMD_NOP: begin
                w_status = srq_pkg::ST_OK;
            end
        endcase
    end

    // chain of slot cells, each fed by its neighbour toward the tail
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        srq_cell #(
            .DEPTH    (DEPTH),
            .ID_WIDTH (ID_WIDTH),
            .IDX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_count (r_count),
            .i_id    (w_id),
            .i_next  ((g == DEPTH - 1) ? w_tail : w_data[(g + 1) % DEPTH]),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    srq_first_match #(
        .DEPTH (DEPTH)
    ) u_first (
        .i_match (w_match),
        .o_any   (w_any),
        .o_index (w_index)
    );

    // update the fill count and the valid flags of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (i_req.ready) begin
                r_s1_valid <= w_accept;
            end
            if (w_s2_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // hold the request's pre-result for the second stage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd    <= w_cmd;
            r_s1_status <= w_status;
            r_s1_head   <= w_op.deq ? w_data[0] : '0;
            r_s1_occ    <= n_count;
        end
    end

    assign w_pos_wide  = {3'b000, w_index};
    assign w_head_wide = {32'd0, r_s1_head};
    assign w_occ_wide  = {4'b0000, r_s1_occ};

    // finish the search and load the output register
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_s2_adv) begin
            if ((r_s1_cmd == srq_pkg::CMD_SRCH) && (r_s1_status == srq_pkg::ST_OK)
                    && !w_any) begin
                r_out_status <= srq_pkg::ST_NOTFOUND;
            end else begin
                r_out_status <= r_s1_status;
            end
            r_out_found    <= w_any;
            r_out_position <= w_any ? w_pos_wide[2:0] : 3'd0;
            r_out_head     <= w_head_wide[31:0];
            r_out_occ      <= w_occ_wide[3:0];
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.found      = r_out_found;
    assign o_rsp.position   = r_out_position;
    assign o_rsp.head_value = r_out_head;
    assign o_rsp.occupancy  = r_out_occ;
endmodule

/* rtl/srq_checker.sv */
// ----------------------------------------------------------------------------
// srq_checker
// Port-level checks on the shifting queue's results, bound to the top level.
// ----------------------------------------------------------------------------
module srq_checker #(
    parameter int DEPTH = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic        i_found,
    input logic [2:0]  i_position,
    input logic [31:0] i_head_value,
    input logic [3:0]  i_occupancy
);
    localparam logic [3:0] FULL_OCC = 4'(DEPTH);

    // a match always reports success
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_found) |-> (i_status == srq_pkg::ST_OK))
        else $error("found set without ok status");

    // no match means position zero
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> (i_position == 3'd0))
        else $error("position set without a match");

    // rejected enqueue only when full, empty only with nothing held
    a_occ_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_status != srq_pkg::ST_FULL) || (i_occupancy == FULL_OCC)) &&
            ((i_status != srq_pkg::ST_EMPTY) ||
             ((i_occupancy == 4'd0) && (i_head_value == 32'd0) && !i_found)))
        else $error("status disagrees with occupancy");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_occupancy) &&
             $stable(i_head_value)))
        else $error("stalled result changed");
endmodule

bind shift_queue_with_search srq_checker #(
    .DEPTH (DEPTH)
) u_srq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_found      (o_rsp.found),
    .i_position   (o_rsp.position),
    .i_head_value (o_rsp.head_value),
    .i_occupancy  (o_rsp.occupancy)
);

/* verif/shift_queue_with_search_tb.sv */
// ----------------------------------------------------------------------------
// shift_queue_with_search_tb
// Self-checking bench for the shifting queue with search. It drives enqueue,
// dequeue, search and no-op requests through the request channel. It keeps its
// own copy of the queue to predict every reply, and it checks each reply
// field by field, in order. Both channels idle at random. One phase holds off
// the reply channel for a long stretch so that the block fills up and stalls.
// ----------------------------------------------------------------------------
module shift_queue_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 8;
    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE_TICKS = 8;

    // traffic mix of one random stretch
    typedef enum int {
        MIX_FILL  = 0,
        MIX_DRAIN = 1,
        MIX_EVEN  = 2
    } t_mix;

    typedef struct packed {
        srq_pkg::t_status status;
        logic             found;
        logic [2:0]       position;
        logic [31:0]      head_value;
        logic [3:0]       occupancy;
    } t_reply;

    logic clk;
    logic rst_n;

    srq_in_if  req_if ();
    srq_out_if rsp_if ();

    shift_queue_with_search #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (32)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow queue and the replies still owed by the block
    logic [31:0] shadow_slots [DEPTH];
    int          shadow_fill;
    t_reply      replies_due [$];
    int          mismatch_count;

    int src_idle_pct;
    int sink_idle_pct;
    int stall_left;

    // run the clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // end the run if the block hangs
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // apply one command to the shadow queue and return the reply it owes
    function automatic t_reply apply_queue_cmd(srq_pkg::t_cmd op, logic [31:0] ident);
        t_reply r;
        r.status     = srq_pkg::ST_OK;
        r.found      = 1'b0;
        r.position   = '0;
        r.head_value = '0;
        case (op)
            srq_pkg::CMD_ENQ: begin
                if (shadow_fill >= DEPTH) begin
                    r.status = srq_pkg::ST_FULL;
                end else begin
                    shadow_slots[shadow_fill] = ident;
                    shadow_fill++;
                end
            end
            srq_pkg::CMD_DEQ: begin
                if (shadow_fill == 0) begin
                    r.status = srq_pkg::ST_EMPTY;
                end else begin
                    r.head_value = shadow_slots[0];
                    for (int i = 0; i + 1 < shadow_fill; i++)
                        shadow_slots[i] = shadow_slots[i + 1];
                    shadow_fill--;
                end
            end
            srq_pkg::CMD_SRCH: begin
                if (shadow_fill == 0) begin
                    r.status = srq_pkg::ST_EMPTY;
                end else begin
                    // scan from the tail so the match nearest the head wins
                    r.status = srq_pkg::ST_NOTFOUND;
                    for (int i = shadow_fill - 1; i >= 0; i--) begin
                        if (shadow_slots[i] == ident) begin
                            r.status   = srq_pkg::ST_OK;
                            r.found    = 1'b1;
                            r.position = 3'(i);
                        end
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = 4'(shadow_fill);
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
        end
    endfunction

    // check replies against the oldest owed one, then log newly taken requests
    always @(posedge clk) begin : watch_channels
        t_reply want;
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (replies_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: reply with none owed, expected nothing, got status %h",
                             $time, rsp_if.status);
                end else begin
                    want = replies_due.pop_front();
                    compare_field("status", 32'(want.status), 32'(rsp_if.status));
                    compare_field("found", 32'(want.found), 32'(rsp_if.found));
                    compare_field("position", 32'(want.position), 32'(rsp_if.position));
                    compare_field("head_value", want.head_value, rsp_if.head_value);
                    compare_field("occupancy", 32'(want.occupancy), 32'(rsp_if.occupancy));
                end
            end
            if (req_if.valid && req_if.ready)
                replies_due.push_back(
                    apply_queue_cmd(srq_pkg::t_cmd'(req_if.cmd), req_if.ident));
        end
    end

    // reply side: hold off while a stall is pending, otherwise idle at random
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // offer one request, after a random gap, and hold it until taken
    task automatic send_req(srq_pkg::t_cmd op, logic [31:0] ident);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.cmd   = op;
        req_if.ident = ident;
        do @(posedge clk); while (!(req_if.valid && req_if.ready));
        @(negedge clk);
    endtask

    // stop offering and wait for every owed reply
    task automatic wait_drain();
        req_if.valid = 1'b0;
        while (replies_due.size() != 0) @(negedge clk);
    endtask

    // choose a command and identifier, biased by the current mix
    task automatic pick_request(t_mix mix, output srq_pkg::t_cmd op,
                                output logic [31:0] ident);
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            op = srq_pkg::CMD_NOP;
        end else if (r < 30) begin
            op = srq_pkg::CMD_SRCH;
        end else begin
            r = $urandom_range(99);
            case (mix)
                MIX_FILL:  op = (r < 75) ? srq_pkg::CMD_ENQ : srq_pkg::CMD_DEQ;
                MIX_DRAIN: op = (r < 25) ? srq_pkg::CMD_ENQ : srq_pkg::CMD_DEQ;
                default:   op = (r < 50) ? srq_pkg::CMD_ENQ : srq_pkg::CMD_DEQ;
            endcase
        end
        // reuse held values for hits, a small pool for duplicates, else anything
        r = $urandom_range(99);
        if (r < 45 && shadow_fill != 0)
            ident = shadow_slots[$urandom_range(shadow_fill - 1)];
        else if (r < 75)
            ident = ($urandom_range(1) ? 32'hFFFF_FFF0 : 32'h0) | 32'($urandom_range(7));
        else
            ident = $urandom();
    endtask

    // empty queue, fill to the brim with extreme values, probe and shift
    task automatic test_directed();
        src_idle_pct  = 26;
        sink_idle_pct = 58;
        send_req(srq_pkg::CMD_SRCH, 32'h0000_0000);
        send_req(srq_pkg::CMD_DEQ,  32'hFFFF_FFFF);
        send_req(srq_pkg::CMD_NOP,  32'h0000_0000);
        send_req(srq_pkg::CMD_ENQ,  32'h8000_0000);
        send_req(srq_pkg::CMD_ENQ,  32'h7FFF_FFFF);
        send_req(srq_pkg::CMD_ENQ,  32'h0000_0000);
        send_req(srq_pkg::CMD_ENQ,  32'hFFFF_FFFF);
        send_req(srq_pkg::CMD_ENQ,  32'h0000_0001);
        send_req(srq_pkg::CMD_ENQ,  32'hAAAA_AAAA);
        send_req(srq_pkg::CMD_ENQ,  32'h5555_5555);
        send_req(srq_pkg::CMD_ENQ,  32'h1234_5678);
        // queue is full: reject the next append
        send_req(srq_pkg::CMD_ENQ,  32'hDEAD_BEEF);
        send_req(srq_pkg::CMD_SRCH, 32'h8000_0000);
        send_req(srq_pkg::CMD_SRCH, 32'h1234_5678);
        send_req(srq_pkg::CMD_SRCH, 32'h0000_0002);
        send_req(srq_pkg::CMD_SRCH, 32'hFFFF_FFFF);
        send_req(srq_pkg::CMD_NOP,  32'hFFFF_FFFF);
        send_req(srq_pkg::CMD_DEQ,  32'h0000_0000);
        send_req(srq_pkg::CMD_DEQ,  32'h0000_0000);
        send_req(srq_pkg::CMD_SRCH, 32'h8000_0000);
        // duplicate entry: the one nearer the head must be reported
        send_req(srq_pkg::CMD_ENQ,  32'h0000_0001);
        send_req(srq_pkg::CMD_SRCH, 32'h0000_0001);
        wait_drain();
    endtask

    // random stretches of filling, draining and mixed traffic
    task automatic test_random(int n_items, int src_pct, int sink_pct);
        t_mix          mix;
        int            stretch_left;
        srq_pkg::t_cmd op;
        logic [31:0]   ident;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stretch_left  = 0;
        mix           = MIX_EVEN;
        for (int k = 0; k < n_items; k++) begin
            if (stretch_left == 0) begin
                mix          = t_mix'($urandom_range(2));
                stretch_left = $urandom_range(40, 8);
            end
            stretch_left--;
            pick_request(mix, op, ident);
            send_req(op, ident);
        end
        wait_drain();
    endtask

    // hold the reply side off while requests keep coming, so the block stalls
    task automatic test_backpressure();
        srq_pkg::t_cmd op;
        logic [31:0]   ident;
        src_idle_pct  = 0;
        sink_idle_pct = 30;
        @(posedge clk);
        stall_left = HOLD_CYCLES;
        @(negedge clk);
        for (int k = 0; k < 24; k++) begin
            pick_request(MIX_FILL, op, ident);
            send_req(op, ident);
        end
        wait_drain();
    endtask

    initial begin
        req_if.valid   = 1'b0;
        req_if.cmd     = srq_pkg::CMD_NOP;
        req_if.ident   = '0;
        rst_n          = 1'b0;
        shadow_fill    = 0;
        mismatch_count = 0;
        stall_left     = 0;
        src_idle_pct   = 0;
        sink_idle_pct  = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(280, 26, 58);
        test_backpressure();
        test_random(280, 58, 26);
        test_random(270, 0, 0);

        // let any stray reply show up before the verdict
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
